// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- hw/rtl/qpa_pkg.sv -----
// Package with types and constants of the positional-access queue.
`timescale 1ns / 1ps
package qpa_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FUNC_W         = 3;
  localparam int POS_W          = 5;
  localparam int CNT_W          = 5;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FN_PUSH   = 3'd0;
  localparam func_t FN_TAKE   = 3'd1;
  localparam func_t FN_READ   = 3'd2;
  localparam func_t FN_DELETE = 3'd3;
  localparam func_t FN_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } res_t;

endpackage

// ----- hw/rtl/qpa_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module qpa_ram #(
  parameter int WIDTH = qpa_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = qpa_pkg::DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/qpa_ctrl.sv -----
// Command sequencer: ring pointers, occupancy and read-modify-write over the RAM.
`timescale 1ns / 1ps
module qpa_ctrl #(
  parameter int DEPTH      = qpa_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = qpa_pkg::DATA_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  qpa_pkg::func_t             func,
  input  logic [DATA_WIDTH-1:0]      data_in,
  input  logic [qpa_pkg::POS_W-1:0]  position,
  output logic                       busy,
  output logic                       ram_we,
  output logic [AW-1:0]              ram_waddr,
  output logic [DATA_WIDTH-1:0]      ram_wdata,
  output logic [AW-1:0]              ram_raddr,
  input  logic [DATA_WIDTH-1:0]      ram_rdata,
  output qpa_pkg::res_t              fin,
  output logic [DATA_WIDTH-1:0]      fin_data,
  output logic [qpa_pkg::CNT_W-1:0]  fin_count
);

  localparam int OW = $clog2(DEPTH + 1);
  localparam int CW = (OW > qpa_pkg::POS_W) ? OW : qpa_pkg::POS_W;
  localparam int MW = (OW > qpa_pkg::CNT_W) ? OW : qpa_pkg::CNT_W;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  qpa_pkg::state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [OW-1:0] occ, occ_next;
  qpa_pkg::func_t cmd_func, cmd_func_next;
  logic [DATA_WIDTH-1:0] cmd_data, cmd_data_next;
  logic [qpa_pkg::POS_W-1:0] cmd_pos, cmd_pos_next;
  logic [AW-1:0] waddr, waddr_next;
  logic [AW-1:0] raddr, raddr_next;
  logic [OW-1:0] left, left_next;

  logic [CW-1:0] pos_w, occ_w;
  logic          pos_ok, pos_last;
  logic [AW-1:0] pos_addr, pos_addr_inc, tail;
  logic          need_read, need_shift;
  logic [MW-1:0] cnt_w;

  assign pos_w        = CW'(cmd_pos);
  assign occ_w        = CW'(occ);
  assign pos_ok       = (cmd_pos != '0) && (pos_w <= occ_w);
  assign pos_last     = (pos_w == occ_w);
  assign pos_addr     = wrap_add(head, AW'(pos_w - CW'(1)));
  assign pos_addr_inc = wrap_add(pos_addr, AW'(1));
  assign tail         = wrap_add(head, AW'(occ));
  assign need_read    = ((cmd_func == qpa_pkg::FN_TAKE) && (occ != '0)) ||
                        ((cmd_func == qpa_pkg::FN_READ) && pos_ok);
  assign need_shift   = (cmd_func == qpa_pkg::FN_DELETE) && pos_ok && !pos_last;

  always_comb begin
    state_next = state;
    case (state)
      qpa_pkg::S_IDLE: begin
        if (start) begin
          state_next = qpa_pkg::S_EXEC;
        end
      end
      qpa_pkg::S_EXEC: begin
        if (need_read) begin
          state_next = qpa_pkg::S_RDWAIT;
        end else if (need_shift) begin
          state_next = qpa_pkg::S_SHIFT;
        end else begin
          state_next = qpa_pkg::S_IDLE;
        end
      end
      qpa_pkg::S_RDWAIT: begin
        state_next = qpa_pkg::S_IDLE;
      end
      qpa_pkg::S_SHIFT: begin
        if (left <= OW'(1)) begin
          state_next = qpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = qpa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = (state != qpa_pkg::S_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = waddr;
    ram_wdata     = cmd_data;
    ram_raddr     = raddr;
    fin.valid     = 1'b0;
    fin.status    = qpa_pkg::ST_OK;
    fin_data      = '0;
    head_next     = head;
    occ_next      = occ;
    cmd_func_next = cmd_func;
    cmd_data_next = cmd_data;
    cmd_pos_next  = cmd_pos;
    waddr_next    = waddr;
    raddr_next    = raddr;
    left_next     = left;
    case (state)
      qpa_pkg::S_IDLE: begin
        if (start) begin
          cmd_func_next = func;
          cmd_data_next = data_in;
          cmd_pos_next  = position;
        end
      end
      qpa_pkg::S_EXEC: begin
        case (cmd_func)
          qpa_pkg::FN_PUSH: begin
            fin.valid = 1'b1;
            if (occ == DEPTH_O) begin
              fin.status = qpa_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = tail;
              occ_next  = occ + OW'(1);
            end
          end
          qpa_pkg::FN_TAKE: begin
            if (occ == '0) begin
              fin.valid  = 1'b1;
              fin.status = qpa_pkg::ST_EMPTY;
            end else begin
              ram_raddr = head;
            end
          end
          qpa_pkg::FN_READ: begin
            if (!pos_ok) begin
              fin.valid  = 1'b1;
              fin.status = qpa_pkg::ST_BADPOS;
            end else begin
              ram_raddr = pos_addr;
            end
          end
          qpa_pkg::FN_DELETE: begin
            if (!pos_ok) begin
              fin.valid  = 1'b1;
              fin.status = qpa_pkg::ST_BADPOS;
            end else if (pos_last) begin
              fin.valid = 1'b1;
              occ_next  = occ - OW'(1);
            end else begin
              ram_raddr  = pos_addr_inc;
              raddr_next = pos_addr_inc;
              waddr_next = pos_addr;
              left_next  = OW'(occ_w - pos_w);
            end
          end
          qpa_pkg::FN_CLEAR: begin
            fin.valid = 1'b1;
            occ_next  = '0;
          end
          default: begin
            fin.valid = 1'b1;
          end
        endcase
      end
      qpa_pkg::S_RDWAIT: begin
        fin.valid = 1'b1;
        fin_data  = ram_rdata;
        if (cmd_func == qpa_pkg::FN_TAKE) begin
          head_next = wrap_add(head, AW'(1));
          occ_next  = occ - OW'(1);
        end
      end
      qpa_pkg::S_SHIFT: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        waddr_next = raddr;
        if (left > OW'(1)) begin
          ram_raddr  = wrap_add(raddr, AW'(1));
          raddr_next = wrap_add(raddr, AW'(1));
          left_next  = left - OW'(1);
        end else begin
          fin.valid = 1'b1;
          occ_next  = occ - OW'(1);
        end
      end
      default: begin
      end
    endcase
    cnt_w     = MW'(occ_next);
    fin_count = cnt_w[qpa_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qpa_pkg::S_IDLE;
      head  <= '0;
      occ   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_func <= cmd_func_next;
    cmd_data <= cmd_data_next;
    cmd_pos  <= cmd_pos_next;
    waddr    <= waddr_next;
    raddr    <= raddr_next;
    left     <= left_next;
  end

endmodule

// ----- hw/rtl/queue_with_positional_access.sv -----
// Top level of the bounded queue with positional read and delete.
//
// Usage: drive func, data_in and position with start high; the command is
// taken at a rising edge where start is high and busy is low. busy stays
// high while the command runs. Every command gives exactly one result: done
// is high for one cycle with data_out, status and count (count is the number
// of stored words after the command). The receiver cannot stall; results are
// never held back and simply appear one cycle each.
// Steps after the accepting edge: push, clear, refused commands and unused
// codes finish in the execute state; take and read go on to a wait state for
// one RAM read; delete at the last position finishes in the execute state,
// otherwise it shifts, one RAM read and write-back per word that moves toward
// the front. done is registered from the final state's result, and busy is
// already low in the cycle where done is high, so the next command can be
// taken at the edge that ends the result, not before the last one is done.
// Reset clears the occupancy and the front pointer; RAM contents are left
// as they are and only written entries are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module queue_with_positional_access #(
  parameter int DEPTH      = qpa_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = qpa_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [qpa_pkg::FUNC_W-1:0] func,
  input  logic [DATA_WIDTH-1:0]      data_in,
  input  logic [qpa_pkg::POS_W-1:0]  position,
  output logic                       done,
  output logic [DATA_WIDTH-1:0]      data_out,
  output logic [1:0]                 status,
  output logic [qpa_pkg::CNT_W-1:0]  count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [DATA_WIDTH-1:0]     ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [DATA_WIDTH-1:0]     ram_rdata;
  qpa_pkg::res_t             fin;
  logic [DATA_WIDTH-1:0]     fin_data;
  logic [qpa_pkg::CNT_W-1:0] fin_count;

  qpa_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  qpa_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .data_in   (data_in),
    .position  (position),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .fin       (fin),
    .fin_data  (fin_data),
    .fin_count (fin_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= fin_data;
    status   <= fin.status;
    count    <= fin_count;
  end

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPLY(a_err_zero, clk, rst, done && (status != qpa_pkg::ST_OK), data_out == '0)
  `ASSERT_IMPLY(a_we_busy, clk, rst, ram_we, busy)
  `ASSERT_IMPLY(a_fin_busy, clk, rst, fin.valid, busy)

endmodule
